### rtl/cfar_detector_assert.svh
// Assertion macros used by the detector module.
`ifndef CFAR_DETECTOR_ASSERT_SVH
`define CFAR_DETECTOR_ASSERT_SVH
// A condition that must hold at every clock edge outside reset.
`define CFAR_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// A condition that, once true, forces another one in the following cycle.
`define CFAR_CHECK_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`endif

### rtl/cfar_pkg.sv
package cfar_pkg;
  localparam int MaxGuard = 8;
  localparam int MaxNoise = 24;
  localparam int MaxFrame = 65535;
  localparam int WinDepth = 1 + 2 * MaxGuard + 2 * MaxNoise;
  localparam int PtrW = $clog2(WinDepth);
  localparam int DvdW = 38;
  localparam int DsrW = 6;
  localparam int CntW = $clog2(DvdW);

  localparam logic [7:0] RegMode = 8'd0;
  localparam logic [7:0] RegGuard = 8'd1;
  localparam logic [7:0] RegNoise = 8'd2;
  localparam logic [7:0] RegOffset = 8'd3;

  localparam logic [1:0] ModeSo = 2'd1;
  localparam logic [1:0] ModeGo = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_PLAN, S_SETUP, S_WALK, S_DIVA, S_WAITA, S_DIVB, S_WAITB, S_RES
  } state_t;
endpackage

### rtl/cfar_div.sv
module cfar_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [cfar_pkg::DvdW-1:0] dividend,
  input  logic [cfar_pkg::DsrW-1:0] divisor,
  output logic done,
  output logic [cfar_pkg::DvdW-1:0] quotient
);
  import cfar_pkg::*;

  logic busy;
  logic [CntW-1:0] cnt;
  logic [DsrW-1:0] rem;
  logic [DsrW-1:0] dsr;
  logic [DvdW-1:0] dvd;
  logic [DsrW:0] trial;
  logic ge;

  assign trial = {rem, dvd[DvdW-1]};
  assign ge = trial >= {1'b0, dsr};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(DvdW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? DsrW'(trial - {1'b0, dsr}) : trial[DsrW-1:0];
      dvd <= {dvd[DvdW-2:0], ge};
    end
  end
endmodule

### rtl/cfar_detector.sv
// Channel  | Direction | Contents
// s_axis   | in        | tdata sample, tlast frame end
// m_axis   | out       | tdata cell result fields, tlast frame done
// cfg      | in        | register index and write data
// Each cell under test walks the window memory through its single read port, then takes one
// or two runs of the shared divider and a result state. The last item of a frame flushes up
// to guard+noise+1 cells. Input is taken only while the sequencer is idle, and a result
// waiting on m_axis_tready stalls the sequencer before its next result. Reset is synchronous.
module cfar_detector (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // sample
  input  logic s_axis_tlast,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // cell_index, cell_value, floor_estimate, detect_level, detected,
  // peak_value, peak_index, peak_found, zero pad
  output logic [167:0] m_axis_tdata,
  output logic m_axis_tlast,          // frame_done
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [31:0] cfg_data
);
  import cfar_pkg::*;
  `include "cfar_detector_assert.svh"

  state_t state, state_next;

  logic [1:0] reg_mode, lat_mode;
  logic [3:0] reg_guard, lat_guard;
  logic [4:0] reg_noise, lat_noise;
  logic [31:0] reg_offset, lat_offset;

  logic [15:0] samples_seen, p, c, cend;
  logic [PtrW-1:0] wptr, cptr, kptr;
  logic last_r;
  logic signed [17:0] kpos;
  logic [6:0] j, jd;
  logic acc_en, acc_inb;
  logic [31:0] rdata;
  logic [31:0] mem [0:WinDepth-1];
  logic [36:0] left_sum, right_sum;
  logic [31:0] cell_val, qa, qb;
  logic [31:0] best_value;
  logic [15:0] best_index;
  logic best_valid;

  logic [5:0] e;
  logic in_acc, emit, load, sogo, is_end, right_edge, det, better;
  logic [31:0] flr;
  logic [32:0] lvl;
  logic [PtrW:0] cstart;
  logic [PtrW:0] kstart;
  logic div_start, div_done;
  logic [DvdW-1:0] div_dvd, div_q;
  logic [DsrW-1:0] div_dsr;

  assign cfg_ready = 1'b1;
  assign e = {2'b0, lat_guard} + {1'b0, lat_noise};
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign emit = last_r || (p >= {10'b0, e});
  assign sogo = (lat_mode == ModeSo) || (lat_mode == ModeGo);
  assign is_end = c == cend;
  assign right_edge = ({1'b0, c} + {11'b0, e}) > {1'b0, p};
  assign cstart = ({1'b0, wptr} >= {1'b0, e}) ? ({1'b0, wptr} - {1'b0, e})
                : ({1'b0, wptr} + (PtrW + 1)'(WinDepth) - {1'b0, e});
  assign kstart = ({1'b0, cptr} >= {1'b0, e}) ? ({1'b0, cptr} - {1'b0, e})
                : ({1'b0, cptr} + (PtrW + 1)'(WinDepth) - {1'b0, e});

  cfar_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dvd),
    .divisor(div_dsr), .done(div_done), .quotient(div_q)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_acc) state_next = S_PLAN;
      S_PLAN:  state_next = emit ? S_SETUP : S_IDLE;
      S_SETUP: state_next = S_WALK;
      S_WALK:  if (j == {e, 1'b1}) state_next = S_DIVA;
      S_DIVA:  state_next = S_WAITA;
      S_WAITA: if (div_done) state_next = sogo ? S_DIVB : S_RES;
      S_DIVB:  state_next = S_WAITB;
      S_WAITB: if (div_done) state_next = S_RES;
      S_RES:   if (load) state_next = is_end ? S_IDLE : S_SETUP;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = state == S_IDLE;
    div_start = (state == S_DIVA) || (state == S_DIVB);
    load = (state == S_RES) && (!m_axis_tvalid || m_axis_tready);
    if (state == S_DIVB) begin
      div_dvd = {1'b0, right_sum};
      div_dsr = {1'b0, lat_noise};
    end else if (sogo) begin
      div_dvd = {1'b0, left_sum};
      div_dsr = {1'b0, lat_noise};
    end else begin
      div_dvd = {1'b0, left_sum} + {1'b0, right_sum};
      div_dsr = {lat_noise, 1'b0};
    end
  end

  always_comb begin
    if (!sogo) flr = qa;
    else if (c < {10'b0, e}) flr = qb;
    else if (right_edge) flr = qa;
    else if (lat_mode == ModeSo) flr = (qa < qb) ? qa : qb;
    else flr = (qa > qb) ? qa : qb;
    lvl = {1'b0, flr} + {1'b0, lat_offset};
    det = {1'b0, cell_val} > lvl;
    better = det && (!best_valid || cell_val > best_value);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      reg_mode <= 2'd0;
      reg_guard <= 4'd2;
      reg_noise <= 5'd8;
      reg_offset <= '0;
      lat_mode <= 2'd0;
      lat_guard <= 4'd2;
      lat_noise <= 5'd8;
      lat_offset <= '0;
      samples_seen <= '0;
      wptr <= '0;
      acc_en <= 1'b0;
      best_value <= '0;
      best_index <= '0;
      best_valid <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        case (cfg_index)
          RegMode:   reg_mode <= cfg_data[1:0];
          RegGuard:  reg_guard <= cfg_data[3:0];
          RegNoise:  reg_noise <= cfg_data[4:0];
          RegOffset: reg_offset <= cfg_data;
          default:   ;
        endcase
      end
      if (in_acc && samples_seen == '0) begin
        lat_mode <= reg_mode;
        lat_guard <= (reg_guard > 4'(MaxGuard)) ? 4'(MaxGuard) : reg_guard;
        lat_noise <= (reg_noise == '0) ? 5'd1
                   : (reg_noise > 5'(MaxNoise)) ? 5'(MaxNoise) : reg_noise;
        lat_offset <= reg_offset;
      end
      acc_en <= (state == S_WALK) && (j <= {e, 1'b0});
      if (load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if ((state == S_PLAN && !emit) || (load && is_end && !last_r)) begin
        samples_seen <= samples_seen + 1'b1;
        wptr <= (wptr == PtrW'(WinDepth - 1)) ? '0 : wptr + 1'b1;
      end
      if (load) begin
        if (is_end && last_r) begin
          samples_seen <= '0;
          wptr <= '0;
          best_value <= '0;
          best_index <= '0;
          best_valid <= 1'b0;
        end else if (better) begin
          best_value <= cell_val;
          best_index <= c;
          best_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem[wptr] <= s_axis_tdata;
      p <= samples_seen;
      last_r <= s_axis_tlast || (samples_seen >= 16'(MaxFrame - 1));
    end
    rdata <= mem[kptr];
    if (state == S_PLAN) begin
      if (p >= {10'b0, e}) begin
        c <= p - {10'b0, e};
        cptr <= cstart[PtrW-1:0];
      end else begin
        c <= '0;
        cptr <= '0;
      end
      cend <= last_r ? p : p - {10'b0, e};
    end
    if (state == S_SETUP) begin
      kpos <= $signed({2'b0, c}) - $signed({12'b0, e});
      kptr <= kstart[PtrW-1:0];
      j <= '0;
      left_sum <= '0;
      right_sum <= '0;
    end
    if (state == S_WALK) begin
      jd <= j;
      acc_inb <= (kpos >= 0) && (kpos <= $signed({2'b0, p}));
      j <= j + 1'b1;
      kpos <= kpos + 18'sd1;
      kptr <= (kptr == PtrW'(WinDepth - 1)) ? '0 : kptr + 1'b1;
    end
    if (acc_en && acc_inb) begin
      if (jd < {2'b0, lat_noise}) left_sum <= left_sum + {5'b0, rdata};
      else if (jd == {1'b0, e}) cell_val <= rdata;
      else if (jd > {1'b0, e} + {3'b0, lat_guard}) right_sum <= right_sum + {5'b0, rdata};
    end
    if (acc_en && !acc_inb && jd == {1'b0, e}) cell_val <= '0;
    if (state == S_WAITA && div_done) qa <= div_q[31:0];
    if (state == S_WAITB && div_done) qb <= div_q[31:0];
    if (load) begin
      m_axis_tdata <= {5'b0, better || best_valid, better ? c : best_index,
                       better ? cell_val : best_value, det, lvl, flr, cell_val, c};
      m_axis_tlast <= is_end && last_r;
      if (!is_end) begin
        c <= c + 1'b1;
        cptr <= (cptr == PtrW'(WinDepth - 1)) ? '0 : cptr + 1'b1;
      end
    end
  end

  `CFAR_CHECK(a_div_only_when_idle_walk, !(div_start && state == S_WALK), "divider start in walk")
  `CFAR_CHECK(a_walk_bound, !(state == S_WALK && j > {e, 1'b1}), "walk ran past window")
  `CFAR_CHECK_NEXT(a_frame_clear, load && is_end && last_r, samples_seen == '0 && !best_valid, "frame state not cleared")
  `CFAR_CHECK_NEXT(a_hold_result, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
endmodule

### test/cfar_checker.sv
`timescale 1ns / 100ps

module cfar_checker (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  input  logic s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic s_axis_tlast,
  input  logic m_axis_tvalid,
  input  logic m_axis_tready,
  input  logic [167:0] m_axis_tdata,
  input  logic m_axis_tlast,
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [31:0] cfg_data,
  output int mismatches,
  output int pending
);
  import cfar_pkg::*;

  typedef struct packed {
    logic [15:0] cell_index;
    logic [31:0] cell_value;
    logic [31:0] floor_estimate;
    logic [32:0] detect_level;
    logic        detected;
    logic [31:0] peak_value;
    logic [15:0] peak_index;
    logic        peak_found;
    logic        frame_done;
  } cell_result_t;

  cell_result_t cell_results_due[$];

  logic [31:0] window_mem [WinDepth];
  int          frame_pos;
  logic [31:0] best_value;
  logic [15:0] best_index;
  logic        best_valid;
  logic [1:0]  reg_mode;
  logic [3:0]  reg_guard;
  logic [4:0]  reg_noise;
  logic [31:0] reg_offset;
  logic [1:0]  frame_mode;
  int          frame_guard;
  int          frame_noise;
  logic [31:0] frame_offset;

  task automatic report(string field, longint unsigned want, longint unsigned got);
    $display("%0t: mismatch in %s, expected %0h, got %0h", $realtime, field, want, got);
    mismatches++;
  endtask

  function automatic logic [36:0] cell_at(int pos, int last);
    if (pos < 0 || pos > last) return '0;
    return {5'd0, window_mem[pos % WinDepth]};
  endfunction

  task automatic score_cell(int c, int last, bit right_edge, bit done);
    int          e;
    logic [36:0] lsum;
    logic [36:0] rsum;
    logic [36:0] lavg;
    logic [36:0] ravg;
    logic [36:0] flr;
    logic [31:0] val;
    cell_result_t r;
    e = frame_guard + frame_noise;
    lsum = '0;
    rsum = '0;
    for (int k = c - e; k <= c - frame_guard - 1; k++) lsum += cell_at(k, last);
    for (int k = c + frame_guard + 1; k <= c + e; k++) rsum += cell_at(k, last);
    if (frame_mode == ModeSo || frame_mode == ModeGo) begin
      lavg = lsum / frame_noise;
      ravg = rsum / frame_noise;
      if (c < e) flr = ravg;
      else if (right_edge) flr = lavg;
      else if (frame_mode == ModeSo) flr = (lavg < ravg) ? lavg : ravg;
      else flr = (lavg > ravg) ? lavg : ravg;
    end else begin
      flr = 37'(({1'b0, lsum} + {1'b0, rsum}) / (2 * frame_noise));
    end
    val = cell_at(c, last);
    r.cell_index = c[15:0];
    r.cell_value = val;
    r.floor_estimate = flr[31:0];
    r.detect_level = {1'b0, flr[31:0]} + {1'b0, frame_offset};
    r.detected = {1'b0, val} > r.detect_level;
    if (r.detected && (!best_valid || val > best_value)) begin
      best_value = val;
      best_index = c[15:0];
      best_valid = 1'b1;
    end
    r.peak_value = best_value;
    r.peak_index = best_index;
    r.peak_found = best_valid;
    r.frame_done = done;
    cell_results_due.push_back(r);
  endtask

  task automatic predict_cells(logic [31:0] sample, logic frame_end);
    int p;
    int e;
    bit last;
    if (frame_pos == 0) begin
      frame_mode = reg_mode;
      frame_guard = (reg_guard > MaxGuard) ? MaxGuard : reg_guard;
      frame_noise = (reg_noise == 0) ? 1 : ((reg_noise > MaxNoise) ? MaxNoise : reg_noise);
      frame_offset = reg_offset;
    end
    p = frame_pos;
    e = frame_guard + frame_noise;
    window_mem[p % WinDepth] = sample;
    last = frame_end || p >= MaxFrame - 1;
    if (!last) begin
      if (p >= e) score_cell(p - e, p, 1'b0, 1'b0);
      frame_pos = p + 1;
    end else begin
      for (int c = (p >= e) ? p - e : 0; c <= p; c++) score_cell(c, p, c + e > p, c == p);
      frame_pos = 0;
      best_value = '0;
      best_index = '0;
      best_valid = 1'b0;
    end
  endtask

  task automatic compare_cell(cell_result_t got);
    cell_result_t want;
    if (cell_results_due.size() == 0) begin
      report("result item with nothing expected", 0, 1);
      return;
    end
    want = cell_results_due.pop_front();
    if (got.cell_index !== want.cell_index)
      report("cell_index", want.cell_index, got.cell_index);
    if (got.cell_value !== want.cell_value)
      report("cell_value", want.cell_value, got.cell_value);
    if (got.floor_estimate !== want.floor_estimate)
      report("floor_estimate", want.floor_estimate, got.floor_estimate);
    if (got.detect_level !== want.detect_level)
      report("detect_level", want.detect_level, got.detect_level);
    if (got.detected !== want.detected) report("detected", want.detected, got.detected);
    if (got.peak_value !== want.peak_value)
      report("peak_value", want.peak_value, got.peak_value);
    if (got.peak_index !== want.peak_index)
      report("peak_index", want.peak_index, got.peak_index);
    if (got.peak_found !== want.peak_found)
      report("peak_found", want.peak_found, got.peak_found);
    if (got.frame_done !== want.frame_done)
      report("frame_done", want.frame_done, got.frame_done);
  endtask

  initial begin
    mismatches = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    cell_result_t got;
    if (rst) begin
      cell_results_due.delete();
      for (int i = 0; i < WinDepth; i++) window_mem[i] = '0;
      frame_pos = 0;
      best_value = '0;
      best_index = '0;
      best_valid = 1'b0;
      reg_mode = '0;
      reg_guard = 4'd2;
      reg_noise = 5'd8;
      reg_offset = '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.cell_index = m_axis_tdata[15:0];
        got.cell_value = m_axis_tdata[47:16];
        got.floor_estimate = m_axis_tdata[79:48];
        got.detect_level = m_axis_tdata[112:80];
        got.detected = m_axis_tdata[113];
        got.peak_value = m_axis_tdata[145:114];
        got.peak_index = m_axis_tdata[161:146];
        got.peak_found = m_axis_tdata[162];
        got.frame_done = m_axis_tlast;
        compare_cell(got);
      end
      if (s_axis_tvalid && s_axis_tready) predict_cells(s_axis_tdata, s_axis_tlast);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegMode: reg_mode = cfg_data[1:0];
          RegGuard: reg_guard = cfg_data[3:0];
          RegNoise: reg_noise = cfg_data[4:0];
          RegOffset: reg_offset = cfg_data;
          default: ;
        endcase
      end
    end
    pending = cell_results_due.size();
  end

endmodule

### test/tb.sv
`timescale 1ns / 100ps

module tb;
  import cfar_pkg::*;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic s_axis_tlast;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [167:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_valid;
  logic cfg_ready;
  logic [7:0] cfg_index;
  logic [31:0] cfg_data;
  int mismatches;
  int pending;
  int items_sent;
  int idle_cycles;
  bit calm;
  bit hold_req;

  localparam int StallLimit = 20000;
  localparam int SettleCycles = 400;

  cfar_detector dut (.*);

  cfar_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send(logic [31:0] sample, logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata <= sample;
    s_axis_tlast <= last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    @(negedge clk);
    items_sent++;
  endtask

  task automatic end_frame_drive;
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained;
    end_frame_drive();
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(logic [7:0] index, logic [31:0] value);
    cfg_index <= index;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [31:0] noisy_sample();
    case ($urandom_range(0, 9))
      0, 1: return $urandom();
      2: return $urandom_range(5000, 100000);
      3: return 32'hFFFF_FFFF;
      default: return $urandom_range(0, 1000);
    endcase
  endfunction

  task automatic random_frame(int len);
    for (int i = 0; i < len; i++) send(noisy_sample(), i == len - 1);
    wait_drained();
  endtask

  // Receiver side: random stalls per item, one long hold on request.
  initial begin
    int w;
    m_axis_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (2000) @(negedge clk);
        hold_req = 1'b0;
      end
      w = calm ? 0 : $urandom_range(0, 4);
      if (w > 0) begin
        m_axis_tready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
      @(negedge clk);
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready) || rst)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int len;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    items_sent = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Single-cell frame touches both edges at once.
    send(32'hFFFF_FFFF, 1'b1);
    wait_drained();
    for (int i = 0; i < 12; i++)
      send((i == 5) ? 32'hFFFF_FFFF : ((i == 7) ? 32'd1 : 32'd0), i == 11);
    wait_drained();
    write_reg(RegMode, ModeSo);
    write_reg(RegGuard, 32'd0);
    write_reg(RegNoise, 32'd1);
    write_reg(8'd7, 32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) send((i == 2) ? 32'h8000_0000 : 32'd3, i == 5);
    wait_drained();
    write_reg(RegMode, 32'd3);
    write_reg(RegGuard, 32'd15);
    write_reg(RegNoise, 32'd0);
    write_reg(RegOffset, 32'hFFFF_FFFF);
    for (int i = 0; i < 4; i++) send(32'hFFFF_FFFF, i == 3);
    wait_drained();
    write_reg(RegMode, ModeGo);
    write_reg(RegGuard, 32'd8);
    write_reg(RegNoise, 32'd31);
    write_reg(RegOffset, 32'd0);
    random_frame(70);

    for (int phase = 0; items_sent < 265; phase++) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 1)) begin
        write_reg(RegMode, $urandom_range(0, 3));
        write_reg(RegGuard, $urandom_range(0, 15));
        write_reg(RegNoise, $urandom_range(0, 31));
        case ($urandom_range(0, 3))
          0: write_reg(RegOffset, 32'd0);
          1: write_reg(RegOffset, 32'hFFFF_FFFF);
          2: write_reg(RegOffset, $urandom());
          default: write_reg(RegOffset, $urandom_range(0, 2000));
        endcase
      end
      if (phase == 2) begin
        calm = 1'b1;
        hold_req = 1'b1;
      end
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 60) : $urandom_range(1, 25);
      random_frame(len);
    end

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/cfar_pkg.sv
rtl/cfar_div.sv
rtl/cfar_detector.sv
test/cfar_checker.sv
test/tb.sv
